/* sv/fce_pkg.sv */
`timescale 1ns / 1ps
package fce_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int IDX_W = 4;
  localparam int CNT_W = 5;
  localparam logic [7:0] AUTO_TEMP = 8'd40;
  localparam logic [7:0] AUTO_DUTY = 8'd80;
  localparam logic [7:0] DUTY_MAX = 8'd255;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_DEL   = 3'd1,
    CMD_NUDGE = 3'd2,
    CMD_SET   = 3'd3,
    CMD_SCALE = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_BADIX = 3'd3,
    ST_ZDIV  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_GAP, S_INS, S_SORT, S_FWD, S_CHK, S_BWD, S_FWD2,
    S_SAT, S_MUL, S_DIV, S_WB, S_DONE
  } fsm_t;

  typedef enum logic [2:0] {
    CELL_HOLD, CELL_LOAD, CELL_PUT, CELL_SORT, CELL_SHIFT, CELL_FWD, CELL_BWD,
    CELL_SAT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic             phase;
    logic [IDX_W-1:0] sel;
    logic [8:0]       temp;
    logic [7:0]       duty;
    logic [7:0]       floor_t;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  function automatic logic [7:0] dflt_temp(input int k);
    logic [7:0] v;
    case (k)
      0: v = 8'd30;
      1: v = 8'd40;
      2: v = 8'd55;
      3: v = 8'd65;
      4: v = 8'd75;
      5: v = 8'd85;
      6: v = 8'd95;
      7: v = 8'd105;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] dflt_duty(input int k);
    logic [7:0] v;
    case (k)
      0: v = 8'd25;
      1: v = 8'd40;
      2: v = 8'd80;
      3: v = 8'd120;
      4: v = 8'd160;
      5: v = 8'd200;
      6: v = 8'd240;
      7: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Floor first, then ceiling, so the ceiling wins when the limits cross.
  function automatic logic [7:0] clamp_temp(input logic signed [10:0] v,
                                            input logic [7:0] fl,
                                            input logic [7:0] cl);
    logic signed [10:0] r;
    r = v;
    if (r < $signed({3'b000, fl})) r = $signed({3'b000, fl});
    if (r > $signed({3'b000, cl})) r = $signed({3'b000, cl});
    return r[7:0];
  endfunction

  function automatic logic [7:0] clamp_duty(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 11'sd0) r = 8'd0;
    else if (v > 11'sd255) r = DUTY_MAX;
    else r = v[7:0];
    return r;
  endfunction

endpackage

/* sv/fce_in_if.sv */
`timescale 1ns / 1ps
interface fce_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] point_select;
  logic       auto_place;
  logic [7:0] temp_value;
  logic [8:0] duty_value;
  logic signed [8:0] temp_delta;
  logic signed [8:0] duty_delta;
  logic [9:0] scale_num;
  logic [9:0] scale_den;
  modport source (output valid, command, point_select, auto_place, temp_value, duty_value,
                  temp_delta, duty_delta, scale_num, scale_den, input ready);
  modport sink (input valid, command, point_select, auto_place, temp_value, duty_value,
                temp_delta, duty_delta, scale_num, scale_den, output ready);
endinterface

/* sv/fce_out_if.sv */
`timescale 1ns / 1ps
interface fce_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] point_index;
  logic [4:0] point_count;
  logic [7:0] entry_temp;
  logic [7:0] entry_duty;
  modport source (output valid, status, point_index, point_count, entry_temp, entry_duty,
                  input ready);
  modport sink (input valid, status, point_index, point_count, entry_temp, entry_duty,
                output ready);
endinterface

/* sv/fce_cell.sv */
`timescale 1ns / 1ps
module fce_cell
  import fce_pkg::*;
#(
  parameter int POS = 0,
  parameter logic [7:0] RST_TEMP = 8'd0,
  parameter logic [7:0] RST_DUTY = 8'd0
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [8:0]       left_temp,
  input  logic [7:0]       left_duty,
  input  logic [IDX_W-1:0] left_tag,
  input  logic [8:0]       right_temp,
  input  logic [7:0]       right_duty,
  input  logic [IDX_W-1:0] right_tag,
  output logic [8:0]       temp,
  output logic [7:0]       duty,
  output logic [IDX_W-1:0] tag
);

  localparam logic [CNT_W-1:0] MY = CNT_W'(POS);
  localparam logic [CNT_W-1:0] MY1 = CNT_W'(POS + 1);
  localparam logic PAR = 1'(POS % 2);

  logic [8:0]         temp_next;
  logic [7:0]         duty_next;
  logic [IDX_W-1:0]   tag_next;
  logic               active;
  logic               has_right;
  logic signed [10:0] fwd_v;
  logic signed [10:0] bwd_v;

  assign active = MY < ctrl.count;
  assign has_right = MY1 < ctrl.count;
  assign fwd_v = $signed({2'b00, left_temp}) + 11'sd1;

  always_comb begin
    bwd_v = $signed({2'b00, right_temp}) - 11'sd1;
    if ($signed({2'b00, temp}) < bwd_v) bwd_v = $signed({2'b00, temp});
    if (bwd_v < $signed({3'b000, ctrl.floor_t})) bwd_v = $signed({3'b000, ctrl.floor_t});
  end

  always_comb begin
    temp_next = temp;
    duty_next = duty;
    tag_next = tag;
    case (ctrl.op)
      CELL_LOAD: begin
        tag_next = IDX_W'(POS);
        if (ctrl.sel == IDX_W'(POS)) begin
          temp_next = ctrl.temp;
          duty_next = ctrl.duty;
        end
      end
      CELL_PUT: begin
        if (ctrl.sel == IDX_W'(POS)) begin
          temp_next = ctrl.temp;
          duty_next = ctrl.duty;
        end
      end
      CELL_SORT: begin
        // Strict compare keeps equal temperatures in their order.
        if (PAR == ctrl.phase) begin
          if (has_right && temp > right_temp) begin
            temp_next = right_temp;
            duty_next = right_duty;
            tag_next = right_tag;
          end
        end else if (POS > 0 && active && left_temp > temp) begin
          temp_next = left_temp;
          duty_next = left_duty;
          tag_next = left_tag;
        end
      end
      CELL_SHIFT: begin
        if (MY >= {1'b0, ctrl.sel} && has_right) begin
          temp_next = right_temp;
          duty_next = right_duty;
        end
      end
      CELL_FWD: begin
        if (POS > 0 && active && fwd_v > $signed({2'b00, temp})) temp_next = fwd_v[8:0];
      end
      CELL_BWD: begin
        if (has_right) temp_next = bwd_v[8:0];
      end
      CELL_SAT: begin
        if (temp > 9'd255) temp_next = 9'd255;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp <= {1'b0, RST_TEMP};
      duty <= RST_DUTY;
    end else begin
      temp <= temp_next;
      duty <= duty_next;
    end
    tag <= tag_next;
  end

endmodule

/* sv/sorted_fan_curve_table_editor.sv */
`timescale 1ns / 1ps
// Channel  Direction  Payload
// in_ch    sink       command, point_select, auto_place, temp/duty values, deltas, scale
// out_ch   source     status, point_index, point_count, entry_temp, entry_duty
// apb      slave      temp_floor at 0x0, temp_ceiling at 0x4
//
// One request at a time. Read, delete and errors go straight to the result; an edit that
// re-sorts runs an odd-even sort and a forward spread pass along the cell row, then, when
// the curve must be spread back from the ceiling, a backward and a second forward pass.
// Add inserts the point, auto add on a non-empty curve first scans the gaps, and scale
// runs the bit-serial divider for each point.
// Reset restores the default curve at once. A result waits in the output register; the
// next request is taken in the cycle after it is loaded.
module sorted_fan_curve_table_editor
  import fce_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  fce_in_if.sink      in_ch,
  fce_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [CNT_W-1:0] NMAX = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] NRST = CNT_W'(MAX_POINTS < 8 ? MAX_POINTS : 8);

  fsm_t state, state_next;
  cell_ctrl_t ctrl;

  logic [7:0] temp_floor, temp_ceiling;
  logic [CNT_W-1:0] count;
  logic [2:0] cmd_r;
  logic [IDX_W-1:0] sel_r;
  logic auto_r;
  logic [7:0] tv_r;
  logic [8:0] dv_r;
  logic signed [8:0] dt_r, dd_r;
  logic [9:0] num_r, den_r;
  logic [7:0] ins_temp;
  logic [8:0] ins_duty;
  logic [IDX_W-1:0] keep;
  logic [CNT_W-1:0] step;
  logic [IDX_W-1:0] best_i;
  logic best_v;
  logic signed [9:0] widest_gap;
  logic [17:0] prod, quo;
  logic [10:0] rem;
  logic [2:0] res_status;
  logic [IDX_W-1:0] res_idx;
  logic [7:0] res_et, res_ed;

  logic [8:0] c_temp [MAX_POINTS];
  logic [7:0] c_duty [MAX_POINTS];
  logic [IDX_W-1:0] c_tag [MAX_POINTS];

  // Derived values.
  logic [CNT_W-1:0] n1;
  logic [IDX_W-1:0] sel_eff, last_i;
  logic sel_oob, is_last;
  logic [8:0] t_a, t_b, t_last, t_0, t_bi, t_bi1;
  logic [7:0] d_a, d_last, d_0, d_bi, d_bi1;
  logic signed [9:0] gap, tail;
  logic [IDX_W-1:0] nk;
  logic [10:0] rem_sh;
  logic rem_ge;

  assign n1 = count - CNT_W'(1);
  assign last_i = n1[IDX_W-1:0];
  assign sel_oob = {1'b0, sel_r} >= count;
  assign sel_eff = sel_oob ? last_i : sel_r;
  assign is_last = step == (NMAX - CNT_W'(1));

  assign t_a = c_temp[step[AW-1:0]];
  assign t_b = c_temp[AW'(step + CNT_W'(1))];
  assign d_a = c_duty[step[AW-1:0]];
  assign t_last = c_temp[last_i[AW-1:0]];
  assign d_last = c_duty[last_i[AW-1:0]];
  assign t_0 = c_temp[0];
  assign d_0 = c_duty[0];
  assign t_bi = c_temp[best_i[AW-1:0]];
  assign t_bi1 = c_temp[AW'(best_i + IDX_W'(1))];
  assign d_bi = c_duty[best_i[AW-1:0]];
  assign d_bi1 = c_duty[AW'(best_i + IDX_W'(1))];
  assign gap = $signed({1'b0, t_b}) - $signed({1'b0, t_a});
  assign tail = $signed({2'b00, temp_ceiling}) - $signed({1'b0, t_last});
  assign rem_sh = {rem[9:0], prod[17]};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  always_comb begin
    nk = '0;
    for (int k = 0; k < MAX_POINTS; k++) begin
      if (c_tag[k] == keep && CNT_W'(k) < count) nk = IDX_W'(k);
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      logic [8:0] lt, rt;
      logic [7:0] ld, rd;
      logic [IDX_W-1:0] lg, rg;
      if (g == 0) begin : g_l0
        assign lt = '0;
        assign ld = '0;
        assign lg = '0;
      end else begin : g_l
        assign lt = c_temp[g-1];
        assign ld = c_duty[g-1];
        assign lg = c_tag[g-1];
      end
      if (g == MAX_POINTS - 1) begin : g_r0
        assign rt = '0;
        assign rd = '0;
        assign rg = '0;
      end else begin : g_r
        assign rt = c_temp[g+1];
        assign rd = c_duty[g+1];
        assign rg = c_tag[g+1];
      end
      fce_cell #(
        .POS(g), .RST_TEMP(dflt_temp(g)), .RST_DUTY(dflt_duty(g))
      ) u_cell (
        .clk, .rst, .ctrl,
        .left_temp(lt), .left_duty(ld), .left_tag(lg),
        .right_temp(rt), .right_duty(rd), .right_tag(rg),
        .temp(c_temp[g]), .duty(c_duty[g]), .tag(c_tag[g])
      );
    end
  endgenerate

  // APB registers.
  assign pready = 1'b1;
  assign prdata = {24'd0, paddr[2] ? temp_ceiling : temp_floor};

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_floor <= 8'd20;
      temp_ceiling <= 8'd110;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) temp_ceiling <= pwdata[7:0];
      else temp_floor <= pwdata[7:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_ch.valid) state_next = S_CMD;
      S_CMD: begin
        state_next = S_DONE;
        case (cmd_r)
          CMD_ADD: begin
            if (count < NMAX) state_next = (auto_r && count != '0) ? S_GAP : S_INS;
          end
          CMD_NUDGE: if (count != '0 && !sel_oob && count > CNT_W'(1)) state_next = S_SORT;
          CMD_SET: begin
            if (count == '0) state_next = S_INS;
            else if (count > CNT_W'(1)) state_next = S_SORT;
          end
          CMD_SCALE: if (den_r != '0 && count != '0) state_next = S_MUL;
          default: ;
        endcase
      end
      S_GAP: if ((step + CNT_W'(1)) >= count) state_next = S_INS;
      S_INS: state_next = (count != '0) ? S_SORT : S_DONE;
      S_SORT: if (is_last) state_next = S_FWD;
      S_FWD: if (is_last) state_next = S_CHK;
      S_CHK: state_next = (t_last > {1'b0, temp_ceiling}) ? S_BWD : S_SAT;
      S_BWD: if (is_last) state_next = S_FWD2;
      S_FWD2: if (is_last) state_next = S_SAT;
      S_SAT: state_next = S_DONE;
      S_MUL: state_next = S_DIV;
      S_DIV: if (step == CNT_W'(17)) state_next = S_WB;
      S_WB: state_next = ((step + CNT_W'(1)) >= count) ? S_DONE : S_MUL;
      S_DONE: if (!out_ch.valid || out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Cell row control.
  always_comb begin
    ctrl.op = CELL_HOLD;
    ctrl.phase = step[0];
    ctrl.sel = sel_eff;
    ctrl.temp = '0;
    ctrl.duty = '0;
    ctrl.floor_t = temp_floor;
    ctrl.count = count;
    in_ch.ready = state == S_IDLE;
    unique case (state)
      S_CMD: begin
        case (cmd_r)
          CMD_DEL: if (count != '0) ctrl.op = CELL_SHIFT;
          CMD_NUDGE: begin
            if (count != '0 && !sel_oob) begin
              ctrl.op = CELL_LOAD;
              ctrl.temp = {1'b0, clamp_temp($signed({2'b00, c_temp[sel_r[AW-1:0]]})
                                            + 11'(dt_r), temp_floor, temp_ceiling)};
              ctrl.duty = clamp_duty($signed({3'b000, c_duty[sel_r[AW-1:0]]})
                                     + 11'(dd_r));
            end
          end
          CMD_SET: begin
            if (count != '0) begin
              ctrl.op = CELL_LOAD;
              ctrl.temp = {1'b0, clamp_temp($signed({3'b000, tv_r}), temp_floor,
                                            temp_ceiling)};
              ctrl.duty = clamp_duty($signed({2'b00, dv_r}));
            end
          end
          default: ;
        endcase
      end
      S_INS: begin
        ctrl.op = CELL_LOAD;
        ctrl.sel = count[IDX_W-1:0];
        ctrl.temp = {1'b0, clamp_temp($signed({3'b000, ins_temp}), temp_floor,
                                      temp_ceiling)};
        ctrl.duty = clamp_duty($signed({2'b00, ins_duty}));
        ctrl.count = count + CNT_W'(1);
      end
      S_SORT: ctrl.op = CELL_SORT;
      S_FWD, S_FWD2: ctrl.op = CELL_FWD;
      S_BWD: ctrl.op = CELL_BWD;
      S_SAT: ctrl.op = CELL_SAT;
      S_CHK: begin
        if (t_last > {1'b0, temp_ceiling}) begin
          ctrl.op = CELL_PUT;
          ctrl.sel = last_i;
          ctrl.temp = {1'b0, temp_ceiling};
          ctrl.duty = d_last;
        end
      end
      S_WB: begin
        ctrl.op = CELL_PUT;
        ctrl.sel = step[IDX_W-1:0];
        ctrl.temp = t_a;
        ctrl.duty = (quo > 18'd255) ? DUTY_MAX : quo[7:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= NRST;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INS) count <= count + CNT_W'(1);
      if (state == S_CMD && cmd_r == CMD_DEL && count != '0) count <= n1;
      if (state == S_DONE && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      cmd_r <= in_ch.command;
      sel_r <= in_ch.point_select;
      auto_r <= in_ch.auto_place;
      tv_r <= in_ch.temp_value;
      dv_r <= in_ch.duty_value;
      dt_r <= in_ch.temp_delta;
      dd_r <= in_ch.duty_delta;
      num_r <= in_ch.scale_num;
      den_r <= in_ch.scale_den;
    end
    if (state == S_DONE && (!out_ch.valid || out_ch.ready)) begin
      out_ch.status <= res_status;
      out_ch.point_index <= res_idx;
      out_ch.point_count <= count;
      out_ch.entry_temp <= res_et;
      out_ch.entry_duty <= res_ed;
    end
    unique case (state)
      S_CMD: begin
        res_status <= ST_OK;
        res_idx <= '0;
        res_et <= '0;
        res_ed <= '0;
        step <= '0;
        best_v <= 1'b0;
        widest_gap <= $signed({1'b0, t_0}) - $signed({2'b00, temp_floor});
        ins_temp <= auto_r ? AUTO_TEMP : tv_r;
        ins_duty <= auto_r ? {1'b0, AUTO_DUTY} : dv_r;
        keep <= sel_eff;
        case (cmd_r)
          CMD_ADD: if (count >= NMAX) res_status <= ST_FULL;
          CMD_DEL: begin
            if (count == '0) res_status <= ST_EMPTY;
            else if ({1'b0, sel_eff} < n1) res_idx <= sel_eff;
            else if (n1 != '0) res_idx <= IDX_W'(n1 - CNT_W'(1));
          end
          CMD_NUDGE: begin
            if (count == '0) res_status <= ST_EMPTY;
            else if (sel_oob) res_status <= ST_BADIX;
          end
          CMD_SET: if (count == '0) ins_temp <= tv_r;
          CMD_SCALE: if (den_r == '0) res_status <= ST_ZDIV;
          CMD_READ: begin
            if (count == '0) res_status <= ST_EMPTY;
            else if (sel_oob) res_status <= ST_BADIX;
            else begin
              res_idx <= sel_r;
              res_et <= c_temp[sel_r[AW-1:0]][7:0];
              res_ed <= c_duty[sel_r[AW-1:0]];
            end
          end
          default: ;
        endcase
        if (cmd_r == CMD_SET && count == '0) ins_duty <= dv_r;
      end
      S_GAP: begin
        if ((step + CNT_W'(1)) < count) begin
          if (gap > widest_gap) begin
            widest_gap <= gap;
            best_i <= step[IDX_W-1:0];
            best_v <= 1'b1;
          end
          step <= step + CNT_W'(1);
        end else begin
          if (tail > widest_gap) begin
            ins_temp <= 8'(({1'b0, t_last} + {2'b00, temp_ceiling}) >> 1);
            ins_duty <= {1'b0, d_last};
          end else if (!best_v) begin
            ins_temp <= 8'(({2'b00, temp_floor} + {1'b0, t_0}) >> 1);
            ins_duty <= {1'b0, d_0};
          end else begin
            ins_temp <= 8'(({1'b0, t_bi} + {1'b0, t_bi1}) >> 1);
            ins_duty <= 9'(({1'b0, d_bi} + {1'b0, d_bi1}) >> 1);
          end
        end
      end
      S_INS: begin
        keep <= count[IDX_W-1:0];
        step <= '0;
      end
      S_SORT, S_FWD, S_BWD, S_FWD2: step <= is_last ? '0 : step + CNT_W'(1);
      S_CHK: begin
        res_idx <= nk;
        step <= '0;
      end
      S_MUL: begin
        prod <= 18'(d_a * num_r);
        rem <= '0;
        quo <= '0;
        keep <= step[IDX_W-1:0];
        step <= '0;
      end
      S_DIV: begin
        rem <= rem_ge ? rem_sh - {1'b0, den_r} : rem_sh;
        quo <= {quo[16:0], rem_ge};
        prod <= {prod[16:0], 1'b0};
        step <= (step == CNT_W'(17)) ? {1'b0, keep} : step + CNT_W'(1);
      end
      S_WB: step <= step + CNT_W'(1);
      default: ;
    endcase
  end

endmodule
